// ===== hw/rtl/dpsr_pkg.sv =====
// shared types, constants and microcode encodings of the distance pd speed regulator
package dpsr_pkg;

    localparam int unsigned FAST_ERROR_THRESHOLD = 128;
    localparam int unsigned FAST_JUMP_THRESHOLD  = 48;
    localparam int unsigned SPEED_CEILING        = 80;

    localparam int unsigned UPC_W = 3;

    localparam logic [UPC_W-1:0] UPC_SEED = 3'd2;
    localparam logic [UPC_W-1:0] UPC_ERR  = 3'd3;

    localparam logic [16:0] FAST_ERR_LIM  = 17'(FAST_ERROR_THRESHOLD);
    localparam logic [24:0] FAST_JUMP_LIM = 25'(FAST_JUMP_THRESHOLD * 256);
    localparam logic [24:0] SPEED_CEIL_Q8 = 25'(SPEED_CEILING * 256);
    localparam logic [23:0] FILT_MAX      = 24'hFF_FFFF;

    typedef enum logic [2:0] {
        CFG_KP_GAIN         = 3'd0,
        CFG_KD_GAIN         = 3'd1,
        CFG_TARGET_DISTANCE = 3'd2,
        CFG_DEADBAND_WIDTH  = 3'd3,
        CFG_CORRECTION_MIN  = 3'd4,
        CFG_CORRECTION_MAX  = 3'd5,
        CFG_FAST_ALPHA      = 3'd6,
        CFG_SLOW_ALPHA      = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_ALPHA,
        MUL_KP,
        MUL_KD
    } t_mul_sel;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_FILT_UPD,
        OP_FILT_SEED,
        OP_ERR,
        OP_ACC_LD,
        OP_CORR,
        OP_OUT
    } t_dp_op;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_JUMP,
        COND_UNSEEDED,
        COND_END
    } t_cond;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    typedef struct packed {
        t_mul_sel         mul_sel;
        t_dp_op           op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic     accept;
        t_mul_sel mul_sel;
        t_dp_op   op;
    } t_dp_ctrl;

    typedef struct packed {
        logic unseeded;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/distance_pd_speed_regulator.sv =====
// top level of the distance pd speed regulator
// each request runs 7 microprogram steps after it is accepted; the last step loads the result register
// a new request is taken only once all 7 steps of the last one are through, on one shared multiplier
// the next request is taken while a result waits; a full result register stalls the last step
// reset: synchronous active low, restores register defaults and clears filter, seed flag
// and previous error
module distance_pd_speed_regulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // distance_sample, base_speed
    input  logic        s_tuser,   // restart_filter
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // speed_command, correction, zero pad
);

    dpsr_pkg::t_dp_ctrl   w_ctrl;
    dpsr_pkg::t_dp_status w_status;

    dpsr_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl)
    );

    dpsr_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_data    (s_tdata),
        .i_in_restart (s_tuser),
        .i_ctrl       (w_ctrl),
        .o_status     (w_status),
        .o_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .o_out_data   (m_tdata)
    );

endmodule

// ===== hw/rtl/dpsr_ucode_rom.sv =====
// microprogram store of the regulator sequencer
module dpsr_ucode_rom (
    input  logic [dpsr_pkg::UPC_W-1:0] i_pc,
    output dpsr_pkg::t_uword           o_word
);

    always_comb begin
        unique case (i_pc)
            3'd0: o_word = '{dpsr_pkg::MUL_ALPHA, dpsr_pkg::OP_NOP,
                             dpsr_pkg::COND_UNSEEDED, dpsr_pkg::UPC_SEED};
            3'd1: o_word = '{dpsr_pkg::MUL_NONE, dpsr_pkg::OP_FILT_UPD,
                             dpsr_pkg::COND_JUMP, dpsr_pkg::UPC_ERR};
            3'd2: o_word = '{dpsr_pkg::MUL_NONE, dpsr_pkg::OP_FILT_SEED,
                             dpsr_pkg::COND_NEXT, dpsr_pkg::UPC_ERR};
            3'd3: o_word = '{dpsr_pkg::MUL_NONE, dpsr_pkg::OP_ERR,
                             dpsr_pkg::COND_NEXT, dpsr_pkg::UPC_ERR};
            3'd4: o_word = '{dpsr_pkg::MUL_KP, dpsr_pkg::OP_NOP,
                             dpsr_pkg::COND_NEXT, dpsr_pkg::UPC_ERR};
            3'd5: o_word = '{dpsr_pkg::MUL_KD, dpsr_pkg::OP_ACC_LD,
                             dpsr_pkg::COND_NEXT, dpsr_pkg::UPC_ERR};
            3'd6: o_word = '{dpsr_pkg::MUL_NONE, dpsr_pkg::OP_CORR,
                             dpsr_pkg::COND_NEXT, dpsr_pkg::UPC_ERR};
            3'd7: o_word = '{dpsr_pkg::MUL_NONE, dpsr_pkg::OP_OUT,
                             dpsr_pkg::COND_END, dpsr_pkg::UPC_ERR};
        endcase
    end

endmodule

// ===== hw/rtl/dpsr_sequencer.sv =====
// step counter and jump logic that walks the microprogram
module dpsr_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dpsr_pkg::t_dp_status i_status,
    output dpsr_pkg::t_dp_ctrl   o_ctrl
);

    dpsr_pkg::t_seq_state         r_state, n_state;
    logic [dpsr_pkg::UPC_W-1:0]   r_pc, n_pc;
    dpsr_pkg::t_uword             w_word;
    logic                         w_run;
    logic                         w_stall;
    logic                         w_accept;

    dpsr_ucode_rom u_rom (
        .i_pc   (r_pc),
        .o_word (w_word)
    );

    assign w_run    = (r_state == dpsr_pkg::SEQ_RUN);
    assign w_stall  = w_run && (w_word.op == dpsr_pkg::OP_OUT) && !i_status.out_free;
    assign w_accept = i_in_valid && (r_state == dpsr_pkg::SEQ_IDLE);

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            dpsr_pkg::SEQ_IDLE: begin
                if (w_accept) begin
                    n_state = dpsr_pkg::SEQ_RUN;
                    n_pc    = '0;
                end
            end
            dpsr_pkg::SEQ_RUN: begin
                if (!w_stall) begin
                    unique case (w_word.cond)
                        dpsr_pkg::COND_NEXT: n_pc = r_pc + 1'b1;
                        dpsr_pkg::COND_JUMP: n_pc = w_word.target;
                        dpsr_pkg::COND_UNSEEDED:
                            n_pc = i_status.unseeded ? w_word.target : r_pc + 1'b1;
                        dpsr_pkg::COND_END: n_state = dpsr_pkg::SEQ_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == dpsr_pkg::SEQ_IDLE);
        o_ctrl.accept  = w_accept;
        o_ctrl.mul_sel = (w_run && !w_stall) ? w_word.mul_sel : dpsr_pkg::MUL_NONE;
        o_ctrl.op      = (w_run && !w_stall) ? w_word.op : dpsr_pkg::OP_NOP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpsr_pkg::SEQ_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

endmodule

// ===== hw/rtl/dpsr_datapath.sv =====
// config registers, filter and pd datapath with one shared multiplier, result register
module dpsr_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_wdata,
    input  logic [31:0]          i_in_data,
    input  logic                 i_in_restart,
    input  dpsr_pkg::t_dp_ctrl   i_ctrl,
    output dpsr_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [23:0]          o_out_data
);

    logic        [15:0] r_kp, r_kd, r_target, r_db;
    logic signed [15:0] r_cmin, r_cmax;
    logic        [8:0]  r_afast, r_aslow;

    logic        [15:0] r_sample;
    logic signed [15:0] r_nominal;
    logic        [23:0] r_filt;
    logic               r_seeded;
    logic signed [17:0] r_prev;
    logic signed [24:0] r_diff;
    logic               r_fast;
    logic signed [17:0] r_err;
    logic signed [18:0] r_de;
    logic signed [41:0] r_prod;
    logic signed [41:0] r_acc;
    logic signed [15:0] r_corr;
    logic               r_ovalid;
    logic        [6:0]  r_speed;
    logic signed [15:0] r_corr_out;

    // accept-cycle filter pre-work
    logic        [15:0] w_sample;
    logic        [23:0] w_filt_eff;
    logic signed [24:0] w_diff;
    logic        [24:0] w_diff_abs;
    logic signed [16:0] w_serr;
    logic        [16:0] w_serr_abs;

    logic signed [16:0] w_ma;
    logic signed [24:0] w_mb;
    logic signed [41:0] w_mprod;

    logic signed [41:0] w_rnd, w_inc, w_fsum;
    logic        [23:0] w_fnext;

    logic        [24:0] w_eround;
    logic signed [17:0] w_e0, w_db, w_eband;

    logic signed [41:0] w_pdsum, w_cfull, w_cmin, w_cmax;
    logic signed [15:0] w_corr;

    logic signed [24:0] w_s;
    logic        [6:0]  w_speed;
    logic               w_out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= 16'd102;
            r_kd     <= 16'd5120;
            r_target <= 16'd320;
            r_db     <= 16'd0;
            r_cmin   <= -16'sd9472;
            r_cmax   <= 16'sd2048;
            r_afast  <= 9'd102;
            r_aslow  <= 9'd64;
        end else if (i_cfg_we) begin
            unique case (dpsr_pkg::t_cfg_idx'(i_cfg_idx))
                dpsr_pkg::CFG_KP_GAIN:         r_kp     <= i_cfg_wdata;
                dpsr_pkg::CFG_KD_GAIN:         r_kd     <= i_cfg_wdata;
                dpsr_pkg::CFG_TARGET_DISTANCE: r_target <= i_cfg_wdata;
                dpsr_pkg::CFG_DEADBAND_WIDTH:  r_db     <= i_cfg_wdata;
                dpsr_pkg::CFG_CORRECTION_MIN:  r_cmin   <= $signed(i_cfg_wdata);
                dpsr_pkg::CFG_CORRECTION_MAX:  r_cmax   <= $signed(i_cfg_wdata);
                dpsr_pkg::CFG_FAST_ALPHA:      r_afast  <= i_cfg_wdata[8:0];
                dpsr_pkg::CFG_SLOW_ALPHA:      r_aslow  <= i_cfg_wdata[8:0];
            endcase
        end
    end

    // restart clears the filter before the jump test
    assign w_sample   = i_in_data[15:0];
    assign w_filt_eff = i_in_restart ? 24'd0 : r_filt;
    assign w_diff     = $signed({1'b0, w_sample, 8'b0}) - $signed({1'b0, w_filt_eff});
    assign w_diff_abs = w_diff[24] ? 25'(-w_diff) : w_diff;
    assign w_serr     = $signed({1'b0, w_sample}) - $signed({1'b0, r_target});
    assign w_serr_abs = w_serr[16] ? 17'(-w_serr) : w_serr;

    // shared multiplier
    always_comb begin
        unique case (i_ctrl.mul_sel)
            dpsr_pkg::MUL_ALPHA: begin
                w_ma = $signed({8'b0, (r_fast ? r_afast : r_aslow)});
                w_mb = r_diff;
            end
            dpsr_pkg::MUL_KP: begin
                w_ma = $signed({1'b0, r_kp});
                w_mb = {{7{r_err[17]}}, r_err};
            end
            dpsr_pkg::MUL_KD: begin
                w_ma = $signed({1'b0, r_kd});
                w_mb = {{6{r_de[18]}}, r_de};
            end
            dpsr_pkg::MUL_NONE: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_mprod = w_ma * w_mb;

    // filter update with rounding and saturation
    assign w_rnd  = r_prod + 42'sd128;
    assign w_inc  = w_rnd >>> 8;
    assign w_fsum = w_inc + $signed({18'b0, r_filt});
    always_comb begin
        priority if (w_fsum < 0) begin
            w_fnext = '0;
        end else if (w_fsum > $signed({18'b0, dpsr_pkg::FILT_MAX})) begin
            w_fnext = dpsr_pkg::FILT_MAX;
        end else begin
            w_fnext = w_fsum[23:0];
        end
    end

    // error against target with deadband
    assign w_eround = {1'b0, r_filt} + 25'd128;
    assign w_e0     = $signed({1'b0, w_eround[24:8]}) - $signed({2'b0, r_target});
    assign w_db     = $signed({2'b0, r_db});
    always_comb begin
        priority if (w_e0 > w_db) begin
            w_eband = w_e0 - w_db;
        end else if (w_e0 < -w_db) begin
            w_eband = w_e0 + w_db;
        end else begin
            w_eband = '0;
        end
    end

    // pd sum, scale and clamp
    assign w_pdsum = r_acc + r_prod;
    assign w_cfull = w_pdsum >>> 4;
    assign w_cmin  = {{26{r_cmin[15]}}, r_cmin};
    assign w_cmax  = {{26{r_cmax[15]}}, r_cmax};
    always_comb begin
        priority if (w_cfull > w_cmax) begin
            w_corr = r_cmax;
        end else if (w_cfull < w_cmin) begin
            w_corr = r_cmin;
        end else begin
            w_corr = w_cfull[15:0];
        end
    end

    // speed command
    assign w_s = $signed({r_nominal[15], r_nominal, 8'b0})
               + $signed({{9{r_corr[15]}}, r_corr});
    always_comb begin
        priority if (w_s > $signed(dpsr_pkg::SPEED_CEIL_Q8)) begin
            w_speed = dpsr_pkg::SPEED_CEIL_Q8[14:8];
        end else if (w_s < 0) begin
            w_speed = '0;
        end else begin
            w_speed = w_s[14:8];
        end
    end

    assign w_out_free = !r_ovalid || i_out_ready;

    // item state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt   <= '0;
            r_seeded <= 1'b0;
            r_prev   <= '0;
        end else begin
            if (i_ctrl.accept && i_in_restart) begin
                r_filt   <= '0;
                r_seeded <= 1'b0;
                r_prev   <= '0;
            end
            unique case (i_ctrl.op)
                dpsr_pkg::OP_FILT_UPD: r_filt <= w_fnext;
                dpsr_pkg::OP_FILT_SEED: begin
                    r_filt   <= {r_sample, 8'b0};
                    r_seeded <= 1'b1;
                end
                dpsr_pkg::OP_CORR: r_prev <= r_err;
                dpsr_pkg::OP_NOP, dpsr_pkg::OP_ERR, dpsr_pkg::OP_ACC_LD,
                dpsr_pkg::OP_OUT: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_sample  <= w_sample;
            r_nominal <= $signed(i_in_data[31:16]);
            r_diff    <= w_diff;
            r_fast    <= (w_serr_abs >= dpsr_pkg::FAST_ERR_LIM)
                      || (w_diff_abs >= dpsr_pkg::FAST_JUMP_LIM);
        end
        if (i_ctrl.mul_sel != dpsr_pkg::MUL_NONE) begin
            r_prod <= w_mprod;
        end
        if (i_ctrl.mul_sel == dpsr_pkg::MUL_KP) begin
            r_de <= $signed({r_err[17], r_err}) - $signed({r_prev[17], r_prev});
        end
        if (i_ctrl.op == dpsr_pkg::OP_ERR) begin
            r_err <= w_eband;
        end
        if (i_ctrl.op == dpsr_pkg::OP_ACC_LD) begin
            r_acc <= r_prod;
        end
        if (i_ctrl.op == dpsr_pkg::OP_CORR) begin
            r_corr <= w_corr;
        end
        if (i_ctrl.op == dpsr_pkg::OP_OUT) begin
            r_speed    <= w_speed;
            r_corr_out <= r_corr;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctrl.op == dpsr_pkg::OP_OUT) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_status.unseeded = !r_seeded;
    assign o_status.out_free = w_out_free;
    assign o_out_valid       = r_ovalid;
    assign o_out_data        = {1'b0, r_corr_out, r_speed};

endmodule
